// ===== hdl/arms_pkg.sv =====
// Shared widths, constants, state encoding and control bundles for the
// running min/max/mean block. No dependencies; every other file imports it.

package arms_pkg;

	// field and datapath widths
	localparam int CODE_W = 10;                 // converter code
	localparam int CNT_W  = 16;                 // sample counter
	localparam int FS_W   = 16;                 // full-scale register
	localparam int MV_W   = 16;                 // millivolt result
	localparam int SUM_W  = CODE_W + CNT_W;     // running sum of codes
	localparam int DEN_W  = CODE_W + CNT_W;     // divisor, 1023 * count
	localparam int NUM_W  = SUM_W + FS_W;       // product fed to the divider
	localparam int STEP_N = (FS_W > MV_W) ? FS_W : MV_W;
	localparam int STEP_W = $clog2(STEP_N);
	localparam int IN_W   = 16;                 // slave tdata, byte padded
	localparam int OUT_W  = 88;                 // master tdata, byte padded
	localparam int LANES  = 4;

	localparam logic [CODE_W-1:0] CODE_MAX = '1;            // full-scale code
	localparam logic [FS_W-1:0]   FS_RESET = FS_W'(5000);
	localparam logic [MV_W-1:0]   SHOWN_MAX = '1;

	// lane assignment of the multiply/divide datapath
	localparam int LN_SAMPLE = 0;
	localparam int LN_MEAN   = 1;
	localparam int LN_MIN    = 2;
	localparam int LN_MAX    = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic step;
	} mul_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

// ===== hdl/arms_stats.sv =====
// Running statistics registers: sample count, code sum, min and max codes.
// Depends on arms_pkg.

module arms_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [arms_pkg::CODE_W-1:0] code,
	output logic [arms_pkg::CNT_W-1:0]  count_q,
	output logic [arms_pkg::SUM_W-1:0]  sum_q,
	output logic [arms_pkg::CODE_W-1:0] min_q,
	output logic [arms_pkg::CODE_W-1:0] max_q,
	output logic                        sat
);
	import arms_pkg::*;

	logic at_limit;

	// count and sum freeze once the counter is full
	assign at_limit = (count_q == {CNT_W{1'b1}});
	assign sat      = at_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= CODE_MAX;
			max_q   <= '0;
		end else if (upd) begin
			if (!at_limit) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + SUM_W'(code);
			end
			if (code < min_q) begin
				min_q <= code;
			end
			if (code > max_q) begin
				max_q <= code;
			end
		end
	end

endmodule

// ===== hdl/arms_mul.sv =====
// Bit-serial shift-add multiplier lane: one multiplier bit per cycle while step
// is set, MSB first. Depends on arms_pkg.

module arms_mul (
	input  logic                       clk,
	input  arms_pkg::mul_ctl_t         ctl,
	input  logic [arms_pkg::SUM_W-1:0] a,
	input  logic                       b,
	output logic [arms_pkg::NUM_W-1:0] prod_q
);
	import arms_pkg::*;

	logic [NUM_W-1:0] addend;

	assign addend = b ? NUM_W'(a) : '0;

	// accumulate: prod = 2*prod + b*a
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			prod_q <= '0;
		end else if (ctl.step) begin
			prod_q <= {prod_q[NUM_W-2:0], 1'b0} + addend;
		end
	end

endmodule

// ===== hdl/arms_div.sv =====
// Restoring radix-2 divider lane: one quotient bit per cycle while step is set.
// Needs num < den * 2^MV_W so the quotient fits MV_W bits. Depends on arms_pkg.

module arms_div (
	input  logic                       clk,
	input  arms_pkg::div_ctl_t         ctl,
	input  logic [arms_pkg::NUM_W-1:0] num,
	input  logic [arms_pkg::DEN_W-1:0] den,
	output logic [arms_pkg::MV_W-1:0]  quo
);
	import arms_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [MV_W-1:0]  bits_q;   // low numerator bits out, quotient bits in
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// shift in next numerator bit and try a subtract
	assign trial = {rem_q, bits_q[MV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[DEN_W+1];
	assign quo   = bits_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= DEN_W'(num[NUM_W-1:MV_W]);
			bits_q <= num[MV_W-1:0];
			den_q  <= den;
		end else if (ctl.step) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			bits_q <= {bits_q[MV_W-2:0], ge};
		end
	end

endmodule

// ===== hdl/adc_running_min_max_mean_top.sv =====
// Top level of the running min/max/mean block: stream ports, sequencer,
// statistics registers and four serial multiply/divide lanes.
// Depends on arms_pkg, arms_stats, arms_mul, arms_div.
//
// channel   | handshake                     | payload
// ----------+-------------------------------+----------------------------------
// s_axis    | s_axis_tvalid / s_axis_tready | tdata: sample_code
// m_axis    | m_axis_tvalid / m_axis_tready | tdata: sample, mean, min, max mV,
//           |                               |        samples_counted, saturated
// cfg       | cfg_wen                       | cfg_wdata: full_scale_mv
//
// After a sample is accepted, the block multiplies the lane operands by full
// scale bit-serially, loads the dividers, runs restoring division (all four lanes
// in parallel) and then writes the result to the output register. No new sample
// is taken until the result is published; a stalled result holds the block in
// its final state until the output register frees up.
// Reset is asynchronous; it clears the statistics and sets full scale to 5000.

module adc_running_min_max_mean_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [arms_pkg::IN_W-1:0]     s_axis_tdata,  // [9:0] sample_code
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] sample_mv, [31:16] mean_mv, [47:32] min_mv, [63:48] max_mv,
	// [79:64] samples_counted, [80] count_saturated, rest zero
	output logic [arms_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_wen,
	input  logic [arms_pkg::FS_W-1:0]     cfg_wdata      // full_scale_mv
);
	import arms_pkg::*;

	state_t              state_q, state_nxt;
	logic [FS_W-1:0]     full_scale_q;
	logic [FS_W-1:0]     fs_sh_q;
	logic [CODE_W-1:0]   code_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                last_step;
	logic                in_acc;
	logic                out_free;
	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;
	mul_ctl_t            mul_ctl;
	div_ctl_t            div_ctl;
	logic                publish;

	logic [CNT_W-1:0]    count;
	logic [SUM_W-1:0]    sum;
	logic [CODE_W-1:0]   min_code;
	logic [CODE_W-1:0]   max_code;
	logic                sat;
	logic [MV_W-1:0]     shown;
	logic [CNT_W+MV_W-1:0] count_ext;
	logic [DEN_W-1:0]    den_mean;

	logic [SUM_W-1:0]    lane_a   [LANES];
	logic [DEN_W-1:0]    lane_den [LANES];
	logic [NUM_W-1:0]    lane_prod[LANES];
	logic [MV_W-1:0]     lane_quo [LANES];

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign last_step = (cnt_q == STEP_W'(STEP_N - 1));

	// statistics
	arms_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (in_acc),
		.code    (s_axis_tdata[CODE_W-1:0]),
		.count_q (count),
		.sum_q   (sum),
		.min_q   (min_code),
		.max_q   (max_code),
		.sat     (sat)
	);

	// mean divisor 1023 * count = count * 1024 - count
	assign den_mean = DEN_W'({count, {CODE_W{1'b0}}}) - DEN_W'(count);

	// reported count saturates at the field maximum
	assign count_ext = (CNT_W+MV_W)'(count);
	assign shown     = (count_ext > (CNT_W+MV_W)'(SHOWN_MAX)) ? SHOWN_MAX
	                                                          : count_ext[MV_W-1:0];

	// lane operands
	always_comb begin
		lane_a[LN_SAMPLE]   = SUM_W'(code_q);
		lane_a[LN_MEAN]     = sum;
		lane_a[LN_MIN]      = SUM_W'(min_code);
		lane_a[LN_MAX]      = SUM_W'(max_code);
		lane_den[LN_SAMPLE] = DEN_W'(CODE_MAX);
		lane_den[LN_MEAN]   = den_mean;
		lane_den[LN_MIN]    = DEN_W'(CODE_MAX);
		lane_den[LN_MAX]    = DEN_W'(CODE_MAX);
	end

	// multiply then divide lanes
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		arms_mul u_mul (
			.clk    (clk),
			.ctl    (mul_ctl),
			.a      (lane_a[i]),
			.b      (fs_sh_q[FS_W-1]),
			.prod_q (lane_prod[i])
		);

		arms_div u_div (
			.clk (clk),
			.ctl (div_ctl),
			.num (lane_prod[i]),
			.den (lane_den[i]),
			.quo (lane_quo[i])
		);
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (last_step) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (last_step) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mul_ctl       = '0;
		div_ctl       = '0;
		publish       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mul_ctl.clr   = 1'b1;
			end
			ST_MUL: begin
				mul_ctl.step = 1'b1;
			end
			ST_LOAD: begin
				div_ctl.load = 1'b1;
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
			end
			ST_DONE: begin
				publish = out_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			full_scale_q <= FS_RESET;
			cnt_q        <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				full_scale_q <= cfg_wdata;
			end
			if (in_acc || div_ctl.load) begin
				cnt_q <= '0;
			end else if (mul_ctl.step || div_ctl.step) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
			if (publish) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q  <= s_axis_tdata[CODE_W-1:0];
			fs_sh_q <= full_scale_q;
		end else if (mul_ctl.step) begin
			fs_sh_q <= {fs_sh_q[FS_W-2:0], 1'b0};
		end
		if (publish) begin
			m_data_q <= OUT_W'({sat, shown, lane_quo[LN_MAX], lane_quo[LN_MIN],
			                    lane_quo[LN_MEAN], lane_quo[LN_SAMPLE]});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== hdl/arms_chk.sv =====
// Port-level checker for the running min/max/mean top, bound to every instance.
// Depends on arms_pkg and adc_running_min_max_mean_top.

module arms_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [arms_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [arms_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                       cfg_wen,
	input logic [arms_pkg::FS_W-1:0]  cfg_wdata
);
	import arms_pkg::*;

	logic [MV_W-1:0] smp_mv, mean_mv, min_mv, max_mv, counted;
	logic            satd;

	assign smp_mv  = m_axis_tdata[MV_W-1:0];
	assign mean_mv = m_axis_tdata[2*MV_W-1:MV_W];
	assign min_mv  = m_axis_tdata[3*MV_W-1:2*MV_W];
	assign max_mv  = m_axis_tdata[4*MV_W-1:3*MV_W];
	assign counted = m_axis_tdata[5*MV_W-1:4*MV_W];
	assign satd    = m_axis_tdata[5*MV_W];

	// one request in flight: ready drops right after a request is taken
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a request is in progress");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// sample lies between min and max
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (min_mv <= smp_mv) && (smp_mv <= max_mv))
		else $error("sample outside min/max");

	// mean lies between min and max
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (min_mv <= mean_mv) && (mean_mv <= max_mv))
		else $error("mean outside min/max");

	// saturation flag only with a full count
	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && satd |-> (CNT_W < MV_W) || (counted == SHOWN_MAX))
		else $error("saturated with count below maximum");

endmodule

bind adc_running_min_max_mean_top arms_chk u_arms_chk (.*);
